@@ hdl/ipts_pkg.sv @@
// Shared types and constants for the I2C page transfer splitter.
// Item structs, configuration struct, state struct and status codes.
// No dependencies.
package ipts_pkg;

	localparam int MaxTransfer = 4096;
	localparam int CfgIndexW   = 3;
	localparam int CfgDataW    = 32;
	localparam int LenW        = 13;
	localparam int AddrW       = 32;

	// Register indexes of the configuration port
	localparam logic [CfgIndexW-1:0] RegDeviceAddress = 3'd0;
	localparam logic [CfgIndexW-1:0] RegDevicePresent = 3'd1;
	localparam logic [CfgIndexW-1:0] RegAddressLength = 3'd2;
	localparam logic [CfgIndexW-1:0] RegPageSize      = 3'd3;
	localparam logic [CfgIndexW-1:0] RegDeviceSize    = 3'd4;

	localparam logic OpStart   = 1'b0;
	localparam logic OpAdvance = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_ARG = 2'd1,
		ST_BAD_CFG = 2'd2,
		ST_IDLE    = 2'd3
	} status_t;

	typedef struct packed {
		logic             operation;
		logic [AddrW-1:0] start_address;
		logic [LenW-1:0]  transfer_length;
		logic             is_read;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [AddrW-1:0] chunk_address;
		logic [LenW-1:0]  chunk_length;
		logic [7:0]       write_address_byte;
		logic [7:0]       read_address_byte;
		logic [2:0]       preamble_length;
		logic [4:0]       start_mask;
		logic             poll_ack;
		logic             last_chunk;
	} out_item_t;

	// Configuration registers plus their precomputed validity check
	typedef struct packed {
		logic [6:0]       device_address;
		logic [2:0]       address_length;
		logic [LenW-1:0]  page_size;
		logic [AddrW-1:0] device_size;
		status_t          check;
	} cfg_t;

	// Transfer state between chunks
	typedef struct packed {
		logic             active;
		logic [AddrW-1:0] next_address;
		logic [LenW-1:0]  bytes_left;
		logic             reading;
	} xfer_state_t;

endpackage

@@ hdl/i2c_page_transfer_splitter_unit.sv @@
// Top level of the I2C page transfer splitter: input register, chunk logic,
// transfer state and result register. Depends on ipts_pkg, ipts_cfg_regs,
// ipts_chunk_calc.
// A result passes through the input register and then the result register;
// an item waits in the input register while the result register is stalled.
// Throughput: one item per cycle while the result side does not stall; the
// transfer state updates as an item moves from the input register into the result register.
// Reset clears all configuration registers, the transfer state and both valids.
module i2c_page_transfer_splitter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ipts_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [ipts_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  ipts_pkg::in_item_t             in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output ipts_pkg::out_item_t            out_item
);
	import ipts_pkg::*;

	cfg_t        cfg;
	in_item_t    item_s1;
	logic        valid_s1;
	out_item_t   res;
	out_item_t   res_s2;
	logic        valid_s2;
	xfer_state_t state_q;
	xfer_state_t state_nxt;
	logic        adv_s1;

	ipts_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ipts_chunk_calc u_calc (
		.cfg  (cfg),
		.cur  (state_q),
		.item (item_s1),
		.res  (res),
		.nxt  (state_nxt)
	);

	// Stage 1 moves on when the result register is free or being taken
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	// Valids and transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_item;
		if (adv_s1)
			res_s2 <= res;
	end

	assign out_valid = valid_s2;
	assign out_item  = res_s2;

	// An error result carries nothing beside its status
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_OK |->
			out_item.chunk_length == '0 && out_item.chunk_address == '0
			&& out_item.preamble_length == '0 && !out_item.last_chunk)
		else $error("error result with nonzero fields");

	// A good chunk is never empty and never longer than a page
	a_chunk_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_OK |->
			out_item.chunk_length != '0 && out_item.chunk_length <= cfg.page_size)
		else $error("chunk length out of range");

	// An active transfer always has bytes left
	a_active_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.active |-> state_q.bytes_left != '0)
		else $error("active transfer with no bytes left");

	// A good non-final chunk leaves a transfer active
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res.status == ST_OK && !res.last_chunk |=> state_q.active)
		else $error("transfer dropped before its last chunk");

endmodule

@@ hdl/ipts_cfg_regs.sv @@
// Configuration register file of the page transfer splitter.
// Holds the device registers and checks them. Depends on ipts_pkg.
module ipts_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ipts_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [ipts_pkg::CfgDataW-1:0]  cfg_data,
	output ipts_pkg::cfg_t                 cfg
);
	import ipts_pkg::*;

	logic [6:0]       device_address_q;
	logic             device_present_q;
	logic [2:0]       address_length_q;
	logic [LenW-1:0]  page_size_q;
	logic [AddrW-1:0] device_size_q;
	logic             page_bad;

	// Register writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= '0;
			device_present_q <= 1'b0;
			address_length_q <= '0;
			page_size_q      <= '0;
			device_size_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegDeviceAddress: device_address_q <= cfg_data[6:0];
				RegDevicePresent: device_present_q <= cfg_data[0];
				RegAddressLength: address_length_q <= cfg_data[2:0];
				RegPageSize:      page_size_q      <= cfg_data[LenW-1:0];
				RegDeviceSize:    device_size_q    <= cfg_data[AddrW-1:0];
				default: ;
			endcase
		end
	end

	// Page must be a nonzero power of two no larger than the max transfer
	assign page_bad = (page_size_q == '0)
		|| (page_size_q > LenW'(MaxTransfer))
		|| ((page_size_q & (page_size_q - LenW'(1))) != '0);

	// Validity check; presence is looked at before the rest
	always_comb begin
		cfg.device_address = device_address_q;
		cfg.address_length = address_length_q;
		cfg.page_size      = page_size_q;
		cfg.device_size    = device_size_q;
		priority if (!device_present_q)
			cfg.check = ST_BAD_ARG;
		else if (address_length_q == 3'd0 || address_length_q > 3'd4)
			cfg.check = ST_BAD_CFG;
		else if (page_bad)
			cfg.check = ST_BAD_CFG;
		else if (device_size_q == '0)
			cfg.check = ST_BAD_CFG;
		else
			cfg.check = ST_OK;
	end

endmodule

@@ hdl/ipts_chunk_calc.sv @@
// Chunk planning logic: checks a start or advance item, forms the chunk,
// its preamble fields and the next transfer state. Depends on ipts_pkg.
module ipts_chunk_calc (
	input  ipts_pkg::cfg_t        cfg,
	input  ipts_pkg::xfer_state_t cur,
	input  ipts_pkg::in_item_t    item,
	output ipts_pkg::out_item_t   res,
	output ipts_pkg::xfer_state_t nxt
);
	import ipts_pkg::*;

	status_t          st;
	logic [LenW-1:0]  page_mask;
	logic [LenW-1:0]  room;
	logic [LenW-1:0]  chunk;
	logic [AddrW-1:0] addr;
	logic [AddrW-1:0] len_ext;
	logic             addr_too_wide;
	logic             rd;
	logic [LenW-1:0]  left;
	logic [7:0]       wbyte;

	always_comb begin
		page_mask = cfg.page_size - LenW'(1);
		len_ext   = {{(AddrW-LenW){1'b0}}, item.transfer_length};
		room      = cfg.page_size - (item.start_address[LenW-1:0] & page_mask);
		wbyte     = {cfg.device_address, 1'b0};

		// Address must fit in the configured number of address bytes
		unique case (cfg.address_length)
			3'd1:    addr_too_wide = item.start_address[31:8] != '0;
			3'd2:    addr_too_wide = item.start_address[31:16] != '0;
			3'd3:    addr_too_wide = item.start_address[31:24] != '0;
			default: addr_too_wide = 1'b0;
		endcase

		nxt   = cur;
		st    = cfg.check;
		chunk = '0;
		addr  = '0;
		rd    = cur.reading;
		left  = '0;

		if (item.operation == OpStart) begin
			nxt.active = 1'b0;
			if (st == ST_OK) begin
				priority if (item.transfer_length == '0
						|| item.transfer_length > LenW'(MaxTransfer)
						|| len_ext > cfg.device_size)
					st = ST_BAD_ARG;
				else if (addr_too_wide)
					st = ST_BAD_ARG;
				else if (item.start_address > cfg.device_size - len_ext)
					st = ST_BAD_ARG;
				else
					st = ST_OK;
			end
			if (st == ST_OK) begin
				rd    = item.is_read;
				addr  = item.start_address;
				chunk = (item.transfer_length < room) ? item.transfer_length : room;
				left  = item.transfer_length - chunk;
				nxt.reading      = rd;
				nxt.next_address = addr + {{(AddrW-LenW){1'b0}}, chunk};
				nxt.bytes_left   = left;
				nxt.active       = left != '0;
			end
		end else begin
			priority if (!cur.active) begin
				st = ST_IDLE;
			end else if (st != ST_OK) begin
				nxt.active = 1'b0;
			end else begin
				addr  = cur.next_address;
				chunk = (cur.bytes_left < cfg.page_size) ? cur.bytes_left : cfg.page_size;
				left  = cur.bytes_left - chunk;
				nxt.next_address = addr + {{(AddrW-LenW){1'b0}}, chunk};
				nxt.bytes_left   = left;
				nxt.active       = left != '0;
			end
		end

		// Result fields; all zero beside the status on an error
		res = '0;
		res.status = st;
		if (st == ST_OK) begin
			res.chunk_address      = addr;
			res.chunk_length       = chunk;
			res.write_address_byte = wbyte;
			res.last_chunk         = left == '0;
			if (rd) begin
				res.read_address_byte = wbyte | 8'h01;
				res.preamble_length   = cfg.address_length + 3'd2;
				res.start_mask        = 5'd1 << cfg.address_length;
			end else begin
				res.preamble_length = cfg.address_length + 3'd1;
				res.poll_ack        = 1'b1;
			end
		end
	end

endmodule

@@ dv/tb_i2c_page_transfer_splitter_unit.sv @@
`timescale 1ns / 1ps
// Testbench for i2c_page_transfer_splitter_unit: directed and random transfer commands,
// each result checked field by field against a behavioral chunk planner. Depends on ipts_pkg.
module tb_i2c_page_transfer_splitter_unit;
	import ipts_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int HoldCycles = 120;
	localparam int ReportMax  = 40;
	localparam int RandPhases = 12;
	localparam int PhaseItems = 85;
	localparam int HoldPhase  = 2;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0]  cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_item_t             in_item = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_item;

	i2c_page_transfer_splitter_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Commands waiting to be sent and chunks the planner expects back
	in_item_t    xfer_cmds[$];
	out_item_t   expected_chunks[$];

	// Shadow of the device registers
	logic [6:0]  cfg_dev_addr = '0;
	logic        cfg_present = 1'b0;
	logic [2:0]  cfg_addr_len = '0;
	logic [12:0] cfg_page = '0;
	logic [31:0] cfg_dev_size = '0;

	// Planner copy of the transfer state
	logic        xfer_active = 1'b0;
	logic [31:0] xfer_next = '0;
	logic [12:0] xfer_left = '0;
	logic        xfer_reading = 1'b0;

	bit          item_taken = 1'b0;
	bit          idle_on = 1'b0;
	bit          hold_go = 1'b0;
	bit          hold_active = 1'b0;
	int          send_gap = 0;
	int          stall_gap = 0;
	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	int unsigned cmds_queued = 0;
	int unsigned items_in = 0;
	int unsigned results_seen = 0;
	int unsigned last_chunks = 0;
	int unsigned settings_run = 0;
	int unsigned status_tally[4] = '{default: 0};

	// Register check shared by start and advance
	function automatic status_t setting_status();
		if (!cfg_present)
			return ST_BAD_ARG;
		if (cfg_addr_len == 3'd0 || cfg_addr_len > 3'd4)
			return ST_BAD_CFG;
		if (cfg_page == '0 || cfg_page > MaxTransfer || (cfg_page & (cfg_page - 1'b1)) != '0)
			return ST_BAD_CFG;
		if (cfg_dev_size == '0)
			return ST_BAD_CFG;
		return ST_OK;
	endfunction

	// Plans the chunk for one command and advances the transfer state
	function automatic out_item_t plan_chunk(input in_item_t cmd);
		status_t     st;
		logic [31:0] addr, len, room, chunk, page;
		out_item_t   r;
		st = setting_status();
		page = 32'(cfg_page);
		r = '0;
		if (cmd.operation == OpStart) begin
			addr = cmd.start_address;
			len = 32'(cmd.transfer_length);
			xfer_active = 1'b0;
			if (st == ST_OK) begin
				if (len == 0 || len > MaxTransfer || len > cfg_dev_size)
					st = ST_BAD_ARG;
				else if (cfg_addr_len < 3'd4 &&
						64'(addr) >= (64'd1 << (8 * cfg_addr_len)))
					st = ST_BAD_ARG;
				else if (addr > cfg_dev_size - len)
					st = ST_BAD_ARG;
			end
			if (st != ST_OK) begin
				r.status = st;
				return r;
			end
			xfer_reading = cmd.is_read;
			room = page - (addr & (page - 1));
			chunk = (len < room) ? len : room;
			xfer_left = 13'(len - chunk);
		end else begin
			if (!xfer_active) begin
				r.status = ST_IDLE;
				return r;
			end
			// registers may have changed since the start
			if (st != ST_OK) begin
				xfer_active = 1'b0;
				r.status = st;
				return r;
			end
			addr = xfer_next;
			chunk = (32'(xfer_left) < page) ? 32'(xfer_left) : page;
			xfer_left = 13'(32'(xfer_left) - chunk);
		end
		xfer_next = addr + chunk;
		xfer_active = (xfer_left != '0);
		r.status = ST_OK;
		r.chunk_address = addr;
		r.chunk_length = 13'(chunk);
		r.write_address_byte = {cfg_dev_addr, 1'b0};
		if (xfer_reading) begin
			r.read_address_byte = {cfg_dev_addr, 1'b1};
			r.preamble_length = cfg_addr_len + 3'd2;
			r.start_mask = 5'd1 << cfg_addr_len;
			r.poll_ack = 1'b0;
		end else begin
			r.read_address_byte = '0;
			r.preamble_length = cfg_addr_len + 3'd1;
			r.start_mask = '0;
			r.poll_ack = 1'b1;
		end
		r.last_chunk = !xfer_active;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= ReportMax)
			$display("mismatch: %s at result %0d: got %0h, expected %0h",
				what, results_seen, got, want);
	endtask

	task automatic check_chunk(input out_item_t got, input out_item_t want);
		if (got.status !== want.status)
			note_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.chunk_address !== want.chunk_address)
			note_mismatch("chunk_address", got.chunk_address, want.chunk_address);
		if (got.chunk_length !== want.chunk_length)
			note_mismatch("chunk_length", 32'(got.chunk_length), 32'(want.chunk_length));
		if (got.write_address_byte !== want.write_address_byte)
			note_mismatch("write_address_byte", 32'(got.write_address_byte),
				32'(want.write_address_byte));
		if (got.read_address_byte !== want.read_address_byte)
			note_mismatch("read_address_byte", 32'(got.read_address_byte),
				32'(want.read_address_byte));
		if (got.preamble_length !== want.preamble_length)
			note_mismatch("preamble_length", 32'(got.preamble_length),
				32'(want.preamble_length));
		if (got.start_mask !== want.start_mask)
			note_mismatch("start_mask", 32'(got.start_mask), 32'(want.start_mask));
		if (got.poll_ack !== want.poll_ack)
			note_mismatch("poll_ack", 32'(got.poll_ack), 32'(want.poll_ack));
		if (got.last_chunk !== want.last_chunk)
			note_mismatch("last_chunk", 32'(got.last_chunk), 32'(want.last_chunk));
	endtask

	// Sample both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				item_taken = 1'b1;
				void'(xfer_cmds.pop_front());
				expected_chunks.push_back(plan_chunk(in_item));
				items_in++;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_chunks.size() == 0)
					note_mismatch("unexpected result, status", 32'(out_item.status), 32'd0);
				else begin
					if (expected_chunks[0].status < 4)
						status_tally[expected_chunks[0].status]++;
					if (expected_chunks[0].status == ST_OK && expected_chunks[0].last_chunk)
						last_chunks++;
					check_chunk(out_item, expected_chunks.pop_front());
				end
			end
		end
	end

	// Command driver: holds an offered item until taken, random gaps in between
	always @(negedge clk) begin
		if (!in_valid || item_taken) begin
			item_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (idle_on && xfer_cmds.size() != 0 && $urandom_range(7, 0) == 0) begin
				send_gap = $urandom_range(5, 0);
				in_valid <= 1'b0;
			end else if (xfer_cmds.size() != 0) begin
				in_valid <= 1'b1;
				in_item <= xfer_cmds[0];
			end else
				in_valid <= 1'b0;
		end
	end

	// Result side stall: random bursts plus one long hold-off
	always @(negedge clk) begin
		if (hold_active)
			out_stall <= 1'b1;
		else if (stall_gap > 0) begin
			stall_gap--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(7, 0) == 0) begin
			stall_gap = $urandom_range(5, 0);
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	// Long hold-off so the block fills up and stalls its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_active = 1'b1;
		repeat (HoldCycles) @(posedge clk);
		hold_active = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	// Writes all five registers; only called with nothing in flight
	task automatic set_device(input logic [6:0] dev, input logic pres, input logic [2:0] alen,
			input logic [12:0] page, input logic [31:0] dsize);
		cfg_dev_addr = dev;
		cfg_present = pres;
		cfg_addr_len = alen;
		cfg_page = page;
		cfg_dev_size = dsize;
		write_reg(RegDeviceAddress, 32'(dev));
		write_reg(RegDevicePresent, 32'(pres));
		write_reg(RegAddressLength, 32'(alen));
		write_reg(RegPageSize, 32'(page));
		write_reg(RegDeviceSize, dsize);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	task automatic push_start(input logic [31:0] addr, input logic [12:0] len, input logic rd);
		in_item_t cmd;
		cmd.operation = OpStart;
		cmd.start_address = addr;
		cmd.transfer_length = len;
		cmd.is_read = rd;
		xfer_cmds.push_back(cmd);
		cmds_queued++;
	endtask

	// Start-only fields carry random junk on an advance
	task automatic push_advance();
		in_item_t cmd;
		cmd.operation = OpAdvance;
		cmd.start_address = $urandom;
		cmd.transfer_length = 13'($urandom);
		cmd.is_read = 1'($urandom);
		xfer_cmds.push_back(cmd);
		cmds_queued++;
	endtask

	task automatic push_noise();
		in_item_t cmd;
		cmd.operation = 1'($urandom);
		cmd.start_address = $urandom;
		cmd.transfer_length = 13'($urandom);
		cmd.is_read = 1'($urandom);
		xfer_cmds.push_back(cmd);
		cmds_queued++;
	endtask

	// A well-formed transfer for the current setting: start then, unless left open, all its advances
	task automatic queue_transfer(input bit open_end);
		logic [31:0] len, span, addr_top, lim, addr, room, head, page;
		int unsigned n_adv;
		page = 32'(cfg_page);
		span = page * 24;
		if (span > MaxTransfer)
			span = MaxTransfer;
		if (span > cfg_dev_size)
			span = cfg_dev_size;
		len = ($urandom_range(3, 0) == 0) ? span : $urandom_range(span, 1);
		addr_top = cfg_dev_size - len;
		if (cfg_addr_len < 3'd4) begin
			lim = 32'd1 << (8 * cfg_addr_len);
			if (addr_top >= lim)
				addr_top = lim - 1;
		end
		case ($urandom_range(3, 0))
			0: addr = addr_top;
			1: addr = $urandom_range(addr_top, 0) & ~(page - 1);
			default: addr = $urandom_range(addr_top, 0);
		endcase
		room = page - (addr & (page - 1));
		head = (len < room) ? len : room;
		n_adv = (len - head + page - 1) / page;
		push_start(addr, 13'(len), 1'($urandom));
		if (!open_end)
			repeat (n_adv) push_advance();
	endtask

	// Random register setting, mostly valid with small pages
	task automatic pick_setting(input bit want_valid);
		logic [6:0]  dev;
		logic        pres;
		logic [2:0]  alen;
		logic [12:0] page;
		logic [31:0] dsize;
		dev = 7'($urandom);
		pres = 1'b1;
		alen = 3'($urandom_range(4, 1));
		page = 13'd1 << (($urandom_range(3, 0) == 0) ? $urandom_range(12, 0)
			: $urandom_range(6, 0));
		case ($urandom_range(4, 0))
			0: dsize = 32'hFFFF_FFFF;
			1: dsize = (alen == 3'd4) ? 32'hFFFF_FFFF : (32'd1 << (8 * alen));
			2: dsize = $urandom_range(300, 1);
			3: dsize = $urandom_range(8192, 1);
			default: dsize = $urandom;
		endcase
		if (dsize == '0)
			dsize = 32'd1;
		if (!want_valid && $urandom_range(4, 0) == 0) begin
			case ($urandom_range(4, 0))
				0: pres = 1'b0;
				1: alen = ($urandom_range(1, 0) == 0) ? 3'd0 : 3'($urandom_range(7, 5));
				2: page = ($urandom_range(1, 0) == 0) ? 13'd0 : 13'($urandom);
				3: dsize = '0;
				default: page = 13'($urandom_range(8191, 4097));
			endcase
		end
		set_device(dev, pres, alen, page, dsize);
	endtask

	task automatic wait_drain();
		while (xfer_cmds.size() != 0 || expected_chunks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int unsigned base;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Nothing configured: advance with no transfer, start on an absent device
		@(posedge clk);
		idle_on = 1'b1;
		push_advance();
		push_start(32'h0, 13'd16, 1'b0);
		wait_drain();

		// Two-byte addressing, 64-byte pages, 64 KiB device
		set_device(7'h7F, 1'b1, 3'd2, 13'd64, 32'd65536);
		push_start(32'h0, 13'd1, 1'b0);
		push_start(32'h0000_FFFF, 13'd1, 1'b1);
		push_start(32'h0001_0000, 13'd1, 1'b0);     // address needs three bytes
		push_start(32'hFFFF_FFFF, 13'h1FFF, 1'b1);  // length over the maximum
		push_start(32'h0, 13'd0, 1'b0);             // empty transfer
		push_start(32'd65535, 13'd2, 1'b0);         // runs off the end of the device
		// unaligned start: short first chunk, full pages, short tail
		push_start(32'h3E, 13'd200, 1'b0);
		repeat (4) push_advance();
		push_advance();                             // nothing left
		// new start replaces the transfer in progress
		push_start(32'h10, 13'd100, 1'b1);
		push_start(32'h20, 13'd10, 1'b0);
		// a rejected start drops the open transfer
		push_start(32'h0, 13'd100, 1'b1);
		push_start(32'h0, 13'd0, 1'b0);
		push_advance();
		// left open across the register change below
		push_start(32'h0, 13'd300, 1'b0);
		wait_drain();

		// Four-byte addressing, largest page and device; open transfer continues
		set_device(7'h00, 1'b1, 3'd4, 13'd4096, 32'hFFFF_FFFF);
		push_advance();
		push_start(32'hFFFF_E000, 13'd4096, 1'b1);
		push_start(32'hFFFF_F000, 13'd4096, 1'b0);
		push_start(32'd4090, 13'd20, 1'b1);
		wait_drain();

		// Page size broken mid-transfer
		set_device(7'h55, 1'b1, 3'd4, 13'd48, 32'hFFFF_FFFF);
		push_advance();
		push_advance();
		wait_drain();

		// Random settings; every fourth phase, the last included, runs without idling
		for (int ph = 0; ph < RandPhases; ph++) begin
			pick_setting(ph == RandPhases - 1);
			@(posedge clk);
			idle_on = (ph != RandPhases - 1) && (ph % 4 != 3);
			if (ph == HoldPhase)
				hold_go = 1'b1;
			// continue whatever the previous phase left open
			push_advance();
			push_advance();
			base = cmds_queued;
			while (cmds_queued - base < PhaseItems) begin
				if (setting_status() == ST_OK && $urandom_range(9, 0) != 0)
					queue_transfer(1'b0);
				else
					push_noise();
			end
			if (setting_status() == ST_OK && $urandom_range(1, 0) == 1)
				queue_transfer(1'b1);
			wait_drain();
		end

		repeat (6) @(posedge clk);
		while (expected_chunks.size() != 0) begin
			note_mismatch("missing result, status", 32'd0, 32'(expected_chunks[0].status));
			void'(expected_chunks.pop_front());
		end

		$display("covered %0d commands over %0d register settings, %0d transfers completed",
			items_in, settings_run, last_chunks);
		$display("results: %0d ok, %0d bad argument, %0d bad setting, %0d no transfer",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/ipts_pkg.sv
hdl/ipts_cfg_regs.sv
hdl/ipts_chunk_calc.sv
hdl/i2c_page_transfer_splitter_unit.sv
dv/tb_i2c_page_transfer_splitter_unit.sv
